>>> sv/per_key_tick_aggregator_defines.svh
// Assertion macros for the per-symbol tick aggregator.
// No dependencies; included by files that carry concurrent checks.
`ifndef PER_KEY_TICK_AGGREGATOR_DEFINES_SVH
`define PER_KEY_TICK_AGGREGATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked implication check, disabled in reset
`define PTAGG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never hold at a clock edge
`define PTAGG_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PTAGG_ASSERT(lbl, clk, rstn, prop, msg)
`define PTAGG_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> sv/ptagg_pkg.sv
// Shared types and constants of the per-symbol tick aggregator.
// No dependencies; imported by every aggregator module but ptagg_ram.
`timescale 1ns / 1ps
`default_nettype none

package ptagg_pkg;

  // Row memory geometry
  localparam int MAX_SYMBOLS = 1024;
  localparam int ADDR_W      = $clog2(MAX_SYMBOLS);

  // Field widths
  localparam int OP_W    = 2;
  localparam int SYM_W   = 10;
  localparam int CFG_W   = 11;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // Stream packing
  localparam int IN_FIELDS_W  = SYM_W + PRICE_W + QTY_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SYM_W + CNT_W + 2 * SUM_W + 2 * PRICE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic {
    ST_SWEEP = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  // One statistics row as stored in memory
  typedef struct packed {
    logic               occ;
    logic [CNT_W-1:0]   cnt;
    logic [SUM_W-1:0]   psum;
    logic [SUM_W-1:0]   qsum;
    logic [PRICE_W-1:0] minp;
    logic [PRICE_W-1:0] maxp;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Accepted request with its active flag
  typedef struct packed {
    op_t                op;
    logic [SYM_W-1:0]   sym;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               ok;
  } req_t;

  // Result of a read request
  typedef struct packed {
    logic               ok;
    logic [SYM_W-1:0]   sym;
    logic [CNT_W-1:0]   cnt;
    logic [SUM_W-1:0]   psum;
    logic [SUM_W-1:0]   qsum;
    logic [PRICE_W-1:0] minp;
    logic [PRICE_W-1:0] maxp;
  } res_t;

  // Sweep control towards the update stage
  typedef struct packed {
    logic              busy;
    logic              sweep_we;
    logic [ADDR_W-1:0] sweep_addr;
  } ctrl_t;

  // Row memory write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    row_t              data;
  } wr_t;

  function automatic logic [ADDR_W-1:0] sym_addr(input logic [SYM_W-1:0] sym);
    return ADDR_W'(sym);
  endfunction

endpackage

`default_nettype wire

>>> sv/ptagg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptagg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/ptagg_ctrl.sv
// Clearing sequencer: sweeps every row of the row memory after reset and on clear.
// Depends on ptagg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptagg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr_req,
  output ptagg_pkg::ctrl_t ctrl
);
  import ptagg_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              last;

  assign last = (cnt_r == ADDR_W'(MAX_SYMBOLS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (clr_req) begin
          state_nxt = ST_SWEEP;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  // Advance the sweep address, restart it from zero otherwise
  always_comb begin
    cnt_nxt = '0;
    if (state_r == ST_SWEEP && !last) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
    end
  end

  // Outputs
  always_comb begin
    ctrl.busy       = 1'b0;
    ctrl.sweep_we   = 1'b0;
    ctrl.sweep_addr = cnt_r;
    unique case (state_r)
      ST_SWEEP: begin
        ctrl.busy     = 1'b1;
        ctrl.sweep_we = 1'b1;
      end
      ST_RUN: begin
        ctrl.busy     = 1'b0;
        ctrl.sweep_we = 1'b0;
      end
      default: begin
        ctrl.busy     = 1'b1;
        ctrl.sweep_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptagg_update.sv
// Read-modify-write stage: merges a tick into its row, forms read results,
// forwards the last written row. Depends on ptagg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptagg_update (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  ptagg_pkg::req_t   req,
  input  ptagg_pkg::ctrl_t  ctrl,
  input  ptagg_pkg::row_t   rd_row,
  output ptagg_pkg::wr_t    wr,
  output logic              push,
  output ptagg_pkg::res_t   push_res,
  output logic              s1_read
);
  import ptagg_pkg::*;

  logic              s1_valid_r;
  req_t              s1_req_r;
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [ADDR_W-1:0] fwd_addr_r;
  row_t              fwd_row_r;

  logic [ADDR_W-1:0] s1_addr;
  logic              hit;
  row_t              cur;
  row_t              upd;
  logic              tick_we;
  logic              show;

  assign s1_addr = sym_addr(s1_req_r.sym);

  // Take the row just written when the memory read missed it
  assign hit = fwd_valid_r && (fwd_addr_r == s1_addr);
  assign cur = hit ? fwd_row_r : rd_row;

  assign tick_we = s1_valid_r && (s1_req_r.op == OP_TICK) && s1_req_r.ok;

  // Merge the tick: an empty row restarts from this tick alone
  always_comb begin
    upd.occ = 1'b1;
    if (!cur.occ) begin
      upd.cnt  = CNT_W'(1);
      upd.psum = SUM_W'(s1_req_r.price);
      upd.qsum = SUM_W'(s1_req_r.qty);
      upd.minp = s1_req_r.price;
      upd.maxp = s1_req_r.price;
    end else begin
      upd.cnt  = cur.cnt + CNT_W'(1);
      upd.psum = cur.psum + SUM_W'(s1_req_r.price);
      upd.qsum = cur.qsum + SUM_W'(s1_req_r.qty);
      upd.minp = (s1_req_r.price < cur.minp) ? s1_req_r.price : cur.minp;
      upd.maxp = (s1_req_r.price > cur.maxp) ? s1_req_r.price : cur.maxp;
    end
  end

  // Memory write: sweep has the port while it runs
  always_comb begin
    wr.we   = tick_we || ctrl.sweep_we;
    wr.addr = ctrl.sweep_we ? ctrl.sweep_addr : s1_addr;
    wr.data = ctrl.sweep_we ? '0 : upd;
  end

  // Read result: inactive ids and empty rows read as zeros
  assign s1_read = s1_valid_r && (s1_req_r.op == OP_READ);
  assign push    = s1_read;
  assign show    = s1_req_r.ok && cur.occ;

  always_comb begin
    push_res.ok   = s1_req_r.ok;
    push_res.sym  = s1_req_r.sym;
    push_res.cnt  = show ? cur.cnt  : '0;
    push_res.psum = show ? cur.psum : '0;
    push_res.qsum = show ? cur.qsum : '0;
    push_res.minp = show ? cur.minp : '0;
    push_res.maxp = show ? cur.maxp : '0;
  end

  // Drop forwarding on a sweep, refresh it on every tick write
  always_comb begin
    fwd_valid_nxt = fwd_valid_r;
    if (ctrl.sweep_we) begin
      fwd_valid_nxt = 1'b0;
    end else if (tick_we) begin
      fwd_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= acc;
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  // Hold request and forwarded row
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_req_r <= req;
    end
    if (tick_we && !ctrl.sweep_we) begin
      fwd_addr_r <= s1_addr;
      fwd_row_r  <= upd;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptagg_outq.sv
// Result queue in front of the output stream, packs each result into tdata/tuser.
// Depends on ptagg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptagg_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  ptagg_pkg::res_t                     push_res,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ptagg_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tuser,
  output logic [ptagg_pkg::OUTQ_CNT_W-1:0]    occ
);
  import ptagg_pkg::*;

  res_t                  q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wp_r, rp_r;
  logic [OUTQ_CNT_W-1:0] occ_r;
  logic                  pop;
  res_t                  head;

  assign out_tvalid = (occ_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign occ        = occ_r;
  assign head       = q_r[rp_r];

  // Pack the head entry, first field in the low bits
  assign out_tdata = {{OUT_PAD_W{1'b0}}, head.maxp, head.minp, head.qsum, head.psum,
                      head.cnt, head.sym};
  assign out_tuser = head.ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      occ_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + OUTQ_PTR_W'(1);
      end
      occ_r <= occ_r + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_res;
    end
  end

endmodule

`default_nettype wire

>>> sv/per_key_tick_aggregator.sv
// Per-symbol tick aggregator: one row of count, price and quantity sums, lowest
// and highest price for each of 1024 symbol ids, kept in a single row memory that
// is read, merged and written back. A tick, read or ignored request is taken every
// cycle; a read result goes from the registered row read through the update stage
// into a four-entry result queue, so reads keep full rate while the output is taken.
// While the result side stalls and the queue could not hold one more result, no
// request is taken. Back-to-back requests to one symbol see the row just written
// through a forwarding register.
// Reset and every clear request start a clearing pass that writes all 1024 rows,
// one row per cycle through the memory's single write port; no request is taken
// while it runs. Configuration writes are taken at any time.
// Depends on ptagg_pkg, ptagg_ram, ptagg_ctrl, ptagg_update, ptagg_outq and
// per_key_tick_aggregator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "per_key_tick_aggregator_defines.svh"

module per_key_tick_aggregator (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: symbols_in_use
  input  logic                             cfg_we,
  input  logic [ptagg_pkg::CFG_W-1:0]      cfg_wdata,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0: symbol, price, quantity, zero pad
  input  logic [ptagg_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: op
  input  logic [ptagg_pkg::OP_W-1:0]       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0: row_symbol, tick_count, price_sum, quantity_sum,
  // lowest_price, highest_price, zero pad
  output logic [ptagg_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: symbol_ok
  output logic                             out_tuser
);
  import ptagg_pkg::*;

  logic [CFG_W-1:0]      cfg_r;
  req_t                  req;
  logic                  acc;
  logic                  clr_req;
  ctrl_t                 ctrl;
  wr_t                   wr;
  logic [ROW_W-1:0]      rd_bits;
  logic                  push;
  res_t                  push_res;
  logic                  s1_read;
  logic [OUTQ_CNT_W-1:0] outq_occ;
  logic [OUTQ_CNT_W-1:0] outq_need;
  logic                  out_pop;

  // Hold the active symbol limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Unpack the request and judge the symbol against the limit
  always_comb begin
    req.op    = op_t'(in_tuser);
    req.sym   = in_tdata[SYM_W-1:0];
    req.price = in_tdata[SYM_W +: PRICE_W];
    req.qty   = in_tdata[SYM_W + PRICE_W +: QTY_W];
    req.ok    = (CFG_W'(req.sym) < cfg_r) && (int'(req.sym) < MAX_SYMBOLS);
  end

  // Take a request only when the queue has room for every result in flight
  assign outq_need = outq_occ + OUTQ_CNT_W'(s1_read);
  assign in_tready = !ctrl.busy && (outq_need <= OUTQ_CNT_W'(OUTQ_DEPTH - 1));
  assign acc       = in_tvalid && in_tready;
  assign clr_req   = acc && (req.op == OP_CLEAR);
  assign out_pop   = out_tvalid && out_tready;

  ptagg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_req (clr_req),
    .ctrl    (ctrl)
  );

  ptagg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_rows (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (acc),
    .raddr (sym_addr(req.sym)),
    .rdata (rd_bits)
  );

  ptagg_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .req      (req),
    .ctrl     (ctrl),
    .rd_row   (row_t'(rd_bits)),
    .wr       (wr),
    .push     (push),
    .push_res (push_res),
    .s1_read  (s1_read)
  );

  ptagg_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (push_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .occ        (outq_occ)
  );

  // Checks
  `PTAGG_ASSERT(a_outq_room, clk, rst_n, (push && !out_pop) |-> (outq_occ < OUTQ_CNT_W'(OUTQ_DEPTH)), "result queue overflow")
  `PTAGG_ASSERT(a_clear_sweeps, clk, rst_n, clr_req |=> ctrl.busy, "clear did not start a sweep")
  `PTAGG_ASSERT_NEVER(a_no_read_in_sweep, clk, rst_n, push && ctrl.busy, "read result during sweep")

endmodule

`default_nettype wire
